// ----- rtl/rtwwm_pkg.sv -----
// Shared types, constants and helper functions of the rich text word wrap measurement block.
package rtwwm_pkg;

    localparam int WORD_GLYPHS = 32;
    localparam int TAG_LEN = 11;
    localparam int EPSILON_FIXED = 1;
    localparam int FILL_W = $clog2(WORD_GLYPHS + 1);
    localparam int WADDR_W = $clog2(WORD_GLYPHS);
    localparam int TFILL_W = 4;
    localparam int TADDR_W = 4;

    localparam logic [9:0]  ROW_MAX = 10'd1023;
    localparam logic [10:0] TALLY_MAX = 11'd1024;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [24:0] SAT25 = 25'h1FFFFFF;

    localparam logic [20:0] CH_SPACE = 21'h20;
    localparam logic [20:0] CH_TAB = 21'h09;
    localparam logic [20:0] CH_NL = 21'h0A;
    localparam logic [20:0] CH_OPEN = 21'h5B;

    localparam logic [2:0] REG_FONT_SIZE = 3'd0;
    localparam logic [2:0] REG_SPACE_GAP = 3'd1;
    localparam logic [2:0] REG_BOX_WIDTH = 3'd2;
    localparam logic [2:0] REG_BOX_HEIGHT = 3'd3;
    localparam logic [2:0] REG_FB_ENABLED = 3'd4;
    localparam logic [2:0] REG_FB_ADVANCE = 3'd5;

    localparam logic [2:0] TAG_COLOR = 3'd0;
    localparam logic [2:0] TAG_ITALIC_ON = 3'd1;
    localparam logic [2:0] TAG_ITALIC_OFF = 3'd2;
    localparam logic [2:0] TAG_COLOR_OFF = 3'd3;
    localparam logic [2:0] TAG_OFF = 3'd4;
    localparam int TAG_KINDS = 5;

    typedef struct packed {
        logic [20:0] char_code;
        logic [15:0] advance;
        logic        present;
        logic        end_of_text;
    } char_word_t;

    typedef struct packed {
        logic [20:0] glyph_code;
        logic        use_fallback;
        logic [31:0] color;
        logic        italic;
        logic [15:0] word_index;
        logic [9:0]  row;
        logic [10:0] rows_total;
        logic        word_overflow;
        logic        is_summary;
        logic        last;
    } glyph_word_t;

    typedef struct packed {
        logic [20:0] code;
        logic        fb;
        logic [31:0] color;
        logic        italic;
    } word_entry_t;

    function automatic logic is_hex(input logic [20:0] c);
        return (c >= 21'h30 && c <= 21'h39) || (c >= 21'h61 && c <= 21'h66) ||
               (c >= 21'h41 && c <= 21'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [20:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 21'h30 && c <= 21'h39) v = 4'(c - 21'h30);
        else if (c >= 21'h61 && c <= 21'h66) v = 4'(c - 21'h57);
        else if (c >= 21'h41 && c <= 21'h46) v = 4'(c - 21'h37);
        return v;
    endfunction

    function automatic logic [3:0] tag_len(input logic [2:0] kind);
        logic [3:0] n;
        case (kind)
            TAG_COLOR:      n = 4'd11;
            TAG_ITALIC_ON:  n = 4'd3;
            TAG_ITALIC_OFF: n = 4'd4;
            TAG_COLOR_OFF:  n = 4'd4;
            TAG_OFF:        n = 4'd5;
            default:        n = 4'd0;
        endcase
        return n;
    endfunction

    // True if character c may stand at position pos of the given tag.
    function automatic logic tag_char_ok(input logic [2:0] kind, input logic [3:0] pos,
                                         input logic [20:0] c);
        logic [7:0] e;
        logic       ok;
        e = 8'h00;
        ok = 1'b0;
        case (kind)
            TAG_COLOR:
            begin
                case (pos)
                    4'd0:    e = 8'h5B;
                    4'd1:    e = 8'h63;
                    4'd2:    e = 8'h3D;
                    4'd3:    e = 8'h23;
                    4'd10:   e = 8'h5D;
                    default: e = 8'h00;
                endcase
            end
            TAG_ITALIC_ON:
            begin
                case (pos)
                    4'd0:    e = 8'h5B;
                    4'd1:    e = 8'h69;
                    4'd2:    e = 8'h5D;
                    default: e = 8'h00;
                endcase
            end
            TAG_ITALIC_OFF:
            begin
                case (pos)
                    4'd0:    e = 8'h5B;
                    4'd1:    e = 8'h2F;
                    4'd2:    e = 8'h69;
                    4'd3:    e = 8'h5D;
                    default: e = 8'h00;
                endcase
            end
            TAG_COLOR_OFF:
            begin
                case (pos)
                    4'd0:    e = 8'h5B;
                    4'd1:    e = 8'h2F;
                    4'd2:    e = 8'h63;
                    4'd3:    e = 8'h5D;
                    default: e = 8'h00;
                endcase
            end
            TAG_OFF:
            begin
                case (pos)
                    4'd0:    e = 8'h5B;
                    4'd1:    e = 8'h6F;
                    4'd2:    e = 8'h66;
                    4'd3:    e = 8'h66;
                    4'd4:    e = 8'h5D;
                    default: e = 8'h00;
                endcase
            end
            default: e = 8'h00;
        endcase
        if (kind == TAG_COLOR && pos >= 4'd4 && pos <= 4'd9) ok = is_hex(c);
        else ok = (e != 8'h00) && (c == {13'd0, e});
        return ok;
    endfunction

    function automatic logic [24:0] sat25(input logic [25:0] v);
        return v[25] ? SAT25 : v[24:0];
    endfunction

endpackage

// ----- rtl/rich_text_word_wrap_measure.sv -----
// Top level of the rich text word wrap measurement block: tag parser, word buffer and wrapper.
//
//  Channel  Direction  Handshake                Word
//  char     in         char_valid / char_stall   rtwwm_pkg::char_word_t
//  glyph    out        glyph_valid / glyph_stall rtwwm_pkg::glyph_word_t
//  cfg      in         cfg_we                    cfg_index, cfg_data
//
// A plain text character is measured in S_TEXT and S_TADD; a character held as a possible tag is checked in S_MATCH.
// Closing a word runs S_CLOSE and S_CLOSE2, then S_EMIT and S_EMIT_OUT for each buffered glyph,
// as the read of the word memory is registered. A failed tag replays up to eleven characters.
// Reset clears all control state at once; the word memory needs no clearing.
// The last word of an item waits in a hold register until the item is known to be done,
// so a stalled output port stops the sequencer only when both output registers are full.
module rich_text_word_wrap_measure (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   char_valid,
    output logic                   char_stall,
    input  rtwwm_pkg::char_word_t  char_word,
    output logic                   glyph_valid,
    input  logic                   glyph_stall,
    output rtwwm_pkg::glyph_word_t glyph_word,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [23:0]            cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MATCH = 4'd1;
    localparam logic [3:0] S_RP = 4'd2;
    localparam logic [3:0] S_TEXT = 4'd3;
    localparam logic [3:0] S_TADD = 4'd4;
    localparam logic [3:0] S_CLOSE = 4'd5;
    localparam logic [3:0] S_CLOSE2 = 4'd6;
    localparam logic [3:0] S_POST = 4'd7;
    localparam logic [3:0] S_EMIT = 4'd8;
    localparam logic [3:0] S_EMIT_OUT = 4'd9;
    localparam logic [3:0] S_END = 4'd10;
    localparam logic [3:0] S_SUM = 4'd11;
    localparam logic [3:0] S_FIN = 4'd12;

    localparam logic [1:0] ER_CLOSE = 2'd0;
    localparam logic [1:0] ER_TEXT = 2'd1;
    localparam logic [1:0] ER_SUM = 2'd2;

    logic [15:0] font_size_reg, font_size_next;
    logic [23:0] space_gap_reg, space_gap_next;
    logic [23:0] box_width_reg, box_width_next;
    logic [23:0] box_height_reg, box_height_next;
    logic        fb_en_reg, fb_en_next;
    logic [15:0] fb_adv_reg, fb_adv_next;

    logic [3:0]  state_reg, state_next;
    logic        rp_mode_reg, rp_mode_next;
    logic        rp_end_reg, rp_end_next;
    logic [1:0]  emit_ret_reg, emit_ret_next;
    logic        close_end_reg, close_end_next;
    logic        close_nl_reg, close_nl_next;
    logic        too_reg, too_next;

    logic [24:0] pen_x_reg, pen_x_next;
    logic [24:0] pen_y_reg, pen_y_next;
    logic [9:0]  row_now_reg, row_now_next;
    logic [10:0] row_tally_reg, row_tally_next;
    logic [24:0] acc_reg, acc_next;
    logic [rtwwm_pkg::FILL_W-1:0] word_fill_reg, word_fill_next;
    logic [15:0] word_counter_reg, word_counter_next;
    logic [31:0] color_now_reg, color_now_next;
    logic        italic_reg, italic_next;
    logic        tags_en_reg, tags_en_next;
    logic [rtwwm_pkg::TFILL_W-1:0] tag_fill_reg, tag_fill_next;
    logic        halted_reg, halted_next;
    logic        word_drop_reg, word_drop_next;
    logic        text_drop_reg, text_drop_next;
    logic [rtwwm_pkg::TFILL_W-1:0] rp_k_reg, rp_k_next;
    logic [rtwwm_pkg::TFILL_W-1:0] rp_n_reg, rp_n_next;
    logic [rtwwm_pkg::FILL_W-1:0] emit_i_reg, emit_i_next;
    logic        pend_v_reg, pend_v_next;
    logic        out_v_reg, out_v_next;

    logic [20:0] cur_code_reg, cur_code_next;
    logic [15:0] cur_adv_reg, cur_adv_next;
    logic        cur_pr_reg, cur_pr_next;
    logic [17:0] glyph_w_reg, glyph_w_next;
    logic [25:0] ww_reg, ww_next;
    logic [9:0]  emit_row_reg, emit_row_next;
    rtwwm_pkg::glyph_word_t pend_reg, pend_next;
    rtwwm_pkg::glyph_word_t out_reg, out_next;

    logic [20:0] tag_code_reg [rtwwm_pkg::TAG_LEN];
    logic [15:0] tag_adv_reg [rtwwm_pkg::TAG_LEN];
    logic        tag_pr_reg [rtwwm_pkg::TAG_LEN];
    logic        tag_we;
    logic [rtwwm_pkg::TADDR_W-1:0] tag_waddr;
    logic [20:0] tag_wcode;
    logic [15:0] tag_wadv;
    logic        tag_wpr;

    rtwwm_pkg::word_entry_t word_mem [rtwwm_pkg::WORD_GLYPHS];
    rtwwm_pkg::word_entry_t mem_rdata;
    rtwwm_pkg::word_entry_t mem_wdata;
    logic        mem_we;
    logic        mem_re;
    logic [rtwwm_pkg::WADDR_W-1:0] mem_waddr;
    logic [rtwwm_pkg::WADDR_W-1:0] mem_raddr;

    logic [3:0]  text_ret;
    logic        out_free;
    logic        can_prod;
    logic        prod_fire;
    rtwwm_pkg::glyph_word_t prod_word;
    logic        push_last;

    logic [rtwwm_pkg::TAG_KINDS-1:0] pat_ok;
    logic        m_partial;
    logic        m_full;
    logic [2:0]  m_kind;
    logic [15:0] a_eff;
    logic [31:0] product;
    logic [25:0] height_sum;
    logic [26:0] fit_sum;
    logic [9:0]  row_inc;
    logic [10:0] tally_inc;
    logic [20:0] ent_code;
    logic [rtwwm_pkg::TADDR_W-1:0] widx;
    logic [rtwwm_pkg::TADDR_W-1:0] rp_addr;
    logic        ent_is_open;

    assign char_stall = (state_reg != S_IDLE);
    assign glyph_valid = out_v_reg;
    assign glyph_word = out_reg;
    assign out_free = !out_v_reg || !glyph_stall;
    assign can_prod = !pend_v_reg || out_free;
    assign text_ret = rp_mode_reg ? S_RP : S_FIN;
    assign row_inc = (row_now_reg < rtwwm_pkg::ROW_MAX) ? row_now_reg + 10'd1 : row_now_reg;
    assign tally_inc = (row_tally_reg < rtwwm_pkg::TALLY_MAX) ? row_tally_reg + 11'd1
                                                               : row_tally_reg;
    assign a_eff = cur_pr_reg ? cur_adv_reg : fb_adv_reg;
    assign product = a_eff * font_size_reg;
    assign height_sum = {1'b0, pen_y_reg} + {10'd0, font_size_reg};
    assign fit_sum = {1'b0, ww_reg} + {2'b00, pen_x_reg};
    assign rp_addr = rp_k_reg;
    assign ent_code = tag_code_reg[rp_addr];
    assign ent_is_open = (ent_code == rtwwm_pkg::CH_OPEN) && tags_en_reg;

    // Tag matching against every pattern in parallel.
    always_comb
    begin
        m_partial = 1'b0;
        m_full = 1'b0;
        m_kind = rtwwm_pkg::TAG_COLOR;
        for (int p = 0; p < rtwwm_pkg::TAG_KINDS; p++)
        begin
            pat_ok[p] = (tag_fill_reg <= rtwwm_pkg::tag_len(3'(p)));
            for (int k = 0; k < rtwwm_pkg::TAG_LEN; k++)
            begin
                if (4'(k) < tag_fill_reg &&
                    !rtwwm_pkg::tag_char_ok(3'(p), 4'(k), tag_code_reg[k]))
                begin
                    pat_ok[p] = 1'b0;
                end
            end
        end
        for (int p = rtwwm_pkg::TAG_KINDS - 1; p >= 0; p--)
        begin
            if (pat_ok[p] && tag_fill_reg == rtwwm_pkg::tag_len(3'(p)))
            begin
                m_full = 1'b1;
                m_kind = 3'(p);
            end
            if (pat_ok[p] && tag_fill_reg < rtwwm_pkg::tag_len(3'(p)))
            begin
                m_partial = 1'b1;
            end
        end
    end

    always_comb
    begin
        font_size_next = font_size_reg;
        space_gap_next = space_gap_reg;
        box_width_next = box_width_reg;
        box_height_next = box_height_reg;
        fb_en_next = fb_en_reg;
        fb_adv_next = fb_adv_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                rtwwm_pkg::REG_FONT_SIZE:  font_size_next = cfg_data[15:0];
                rtwwm_pkg::REG_SPACE_GAP:  space_gap_next = cfg_data;
                rtwwm_pkg::REG_BOX_WIDTH:  box_width_next = cfg_data;
                rtwwm_pkg::REG_BOX_HEIGHT: box_height_next = cfg_data;
                rtwwm_pkg::REG_FB_ENABLED: fb_en_next = cfg_data[0];
                rtwwm_pkg::REG_FB_ADVANCE: fb_adv_next = cfg_data[15:0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        rp_mode_next = rp_mode_reg;
        rp_end_next = rp_end_reg;
        emit_ret_next = emit_ret_reg;
        close_end_next = close_end_reg;
        close_nl_next = close_nl_reg;
        too_next = too_reg;
        pen_x_next = pen_x_reg;
        pen_y_next = pen_y_reg;
        row_now_next = row_now_reg;
        row_tally_next = row_tally_reg;
        acc_next = acc_reg;
        word_fill_next = word_fill_reg;
        word_counter_next = word_counter_reg;
        color_now_next = color_now_reg;
        italic_next = italic_reg;
        tags_en_next = tags_en_reg;
        tag_fill_next = tag_fill_reg;
        halted_next = halted_reg;
        word_drop_next = word_drop_reg;
        text_drop_next = text_drop_reg;
        rp_k_next = rp_k_reg;
        rp_n_next = rp_n_reg;
        emit_i_next = emit_i_reg;
        cur_code_next = cur_code_reg;
        cur_adv_next = cur_adv_reg;
        cur_pr_next = cur_pr_reg;
        glyph_w_next = glyph_w_reg;
        ww_next = ww_reg;
        emit_row_next = emit_row_reg;
        tag_we = 1'b0;
        tag_waddr = tag_fill_reg;
        tag_wcode = char_word.char_code;
        tag_wadv = char_word.advance;
        tag_wpr = char_word.present;
        mem_we = 1'b0;
        mem_re = 1'b0;
        mem_waddr = word_fill_reg[rtwwm_pkg::WADDR_W-1:0];
        mem_raddr = emit_i_reg[rtwwm_pkg::WADDR_W-1:0];
        mem_wdata.code = cur_code_reg;
        mem_wdata.fb = !cur_pr_reg;
        mem_wdata.color = color_now_reg;
        mem_wdata.italic = italic_reg;
        prod_fire = 1'b0;
        prod_word = '0;
        push_last = 1'b0;
        widx = (tag_fill_reg >= 4'(rtwwm_pkg::TAG_LEN)) ? 4'(rtwwm_pkg::TAG_LEN - 1)
                                                        : tag_fill_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (char_valid)
                begin
                    cur_code_next = char_word.char_code;
                    cur_adv_next = char_word.advance;
                    cur_pr_next = char_word.present;
                    rp_mode_next = 1'b0;
                    if (char_word.end_of_text)
                    begin
                        state_next = S_END;
                    end
                    else if (halted_reg)
                    begin
                        state_next = S_FIN;
                    end
                    else if (tag_fill_reg == '0 &&
                             !(char_word.char_code == rtwwm_pkg::CH_OPEN && tags_en_reg))
                    begin
                        state_next = S_TEXT;
                    end
                    else
                    begin
                        tag_we = 1'b1;
                        tag_waddr = widx;
                        tag_fill_next = widx + 4'd1;
                        state_next = S_MATCH;
                    end
                end
            end
            S_MATCH:
            begin
                if (m_full)
                begin
                    tag_fill_next = '0;
                    case (m_kind)
                        rtwwm_pkg::TAG_COLOR:
                            color_now_next = {8'hFF,
                                rtwwm_pkg::hex_val(tag_code_reg[8]),
                                rtwwm_pkg::hex_val(tag_code_reg[9]),
                                rtwwm_pkg::hex_val(tag_code_reg[6]),
                                rtwwm_pkg::hex_val(tag_code_reg[7]),
                                rtwwm_pkg::hex_val(tag_code_reg[4]),
                                rtwwm_pkg::hex_val(tag_code_reg[5])};
                        rtwwm_pkg::TAG_ITALIC_ON:  italic_next = 1'b1;
                        rtwwm_pkg::TAG_ITALIC_OFF: italic_next = 1'b0;
                        rtwwm_pkg::TAG_COLOR_OFF:  color_now_next = '1;
                        default:                   tags_en_next = 1'b0;
                    endcase
                    state_next = S_FIN;
                end
                else if (m_partial)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    rp_n_next = tag_fill_reg;
                    rp_k_next = '0;
                    tag_fill_next = '0;
                    rp_end_next = 1'b0;
                    state_next = S_RP;
                end
            end
            S_RP:
            begin
                if (rp_k_reg >= rp_n_reg || (rp_k_reg != '0 && halted_reg))
                begin
                    state_next = rp_end_reg ? S_END : S_FIN;
                end
                else if (rp_k_reg == '0 || (tag_fill_reg == '0 && !ent_is_open))
                begin
                    cur_code_next = ent_code;
                    cur_adv_next = tag_adv_reg[rp_addr];
                    cur_pr_next = tag_pr_reg[rp_addr];
                    rp_mode_next = 1'b1;
                    rp_k_next = rp_k_reg + 4'd1;
                    state_next = S_TEXT;
                end
                else
                begin
                    tag_we = 1'b1;
                    tag_waddr = tag_fill_reg;
                    tag_wcode = ent_code;
                    tag_wadv = tag_adv_reg[rp_addr];
                    tag_wpr = tag_pr_reg[rp_addr];
                    tag_fill_next = tag_fill_reg + 4'd1;
                    rp_k_next = rp_k_reg + 4'd1;
                end
            end
            S_TEXT:
            begin
                if (halted_reg)
                begin
                    state_next = text_ret;
                end
                else if (height_sum > {2'b00, box_height_reg})
                begin
                    halted_next = 1'b1;
                    emit_row_next = '0;
                    emit_ret_next = ER_TEXT;
                    emit_i_next = '0;
                    state_next = S_EMIT;
                end
                else if (cur_code_reg == rtwwm_pkg::CH_SPACE ||
                         cur_code_reg == rtwwm_pkg::CH_TAB ||
                         cur_code_reg == rtwwm_pkg::CH_NL)
                begin
                    close_nl_next = (cur_code_reg == rtwwm_pkg::CH_NL);
                    close_end_next = 1'b0;
                    state_next = S_CLOSE;
                end
                else if (!cur_pr_reg && !fb_en_reg)
                begin
                    state_next = text_ret;
                end
                else
                begin
                    glyph_w_next = product[31:14];
                    if (word_fill_reg < rtwwm_pkg::FILL_W'(rtwwm_pkg::WORD_GLYPHS))
                    begin
                        mem_we = 1'b1;
                        word_fill_next = word_fill_reg + 1'b1;
                    end
                    else
                    begin
                        word_drop_next = 1'b1;
                        text_drop_next = 1'b1;
                    end
                    state_next = S_TADD;
                end
            end
            S_TADD:
            begin
                acc_next = rtwwm_pkg::sat25({1'b0, acc_reg} + {8'd0, glyph_w_reg});
                state_next = text_ret;
            end
            S_CLOSE:
            begin
                if (pen_x_reg <= 25'(rtwwm_pkg::EPSILON_FIXED))
                    ww_next = {1'b0, acc_reg};
                else
                    ww_next = {2'b00, space_gap_reg} + {1'b0, acc_reg};
                state_next = S_CLOSE2;
            end
            S_CLOSE2:
            begin
                too_next = fit_sum > {3'b000, box_width_reg};
                emit_row_next = row_now_reg;
                if (fit_sum > {3'b000, box_width_reg})
                begin
                    emit_row_next = row_inc;
                    row_now_next = row_inc;
                    row_tally_next = tally_inc;
                    if (!close_end_reg)
                    begin
                        pen_x_next = '0;
                        pen_y_next = rtwwm_pkg::sat25(height_sum);
                    end
                end
                emit_ret_next = close_end_reg ? ER_SUM : ER_CLOSE;
                emit_i_next = '0;
                state_next = S_EMIT;
            end
            S_POST:
            begin
                word_fill_next = '0;
                acc_next = '0;
                word_drop_next = 1'b0;
                if (word_counter_reg < rtwwm_pkg::COUNT_MAX)
                    word_counter_next = word_counter_reg + 16'd1;
                if (close_nl_reg && !too_reg)
                begin
                    pen_x_next = '0;
                    pen_y_next = rtwwm_pkg::sat25(height_sum);
                    row_now_next = row_inc;
                    row_tally_next = tally_inc;
                end
                else
                begin
                    pen_x_next = rtwwm_pkg::sat25(ww_reg + {1'b0, pen_x_reg});
                end
                state_next = text_ret;
            end
            S_EMIT:
            begin
                if (emit_i_reg == word_fill_reg)
                begin
                    case (emit_ret_reg)
                        ER_CLOSE: state_next = S_POST;
                        ER_TEXT:  state_next = text_ret;
                        default:  state_next = S_SUM;
                    endcase
                end
                else
                begin
                    mem_re = 1'b1;
                    state_next = S_EMIT_OUT;
                end
            end
            S_EMIT_OUT:
            begin
                if (can_prod)
                begin
                    prod_fire = 1'b1;
                    prod_word.glyph_code = mem_rdata.code;
                    prod_word.use_fallback = mem_rdata.fb;
                    prod_word.color = mem_rdata.color;
                    prod_word.italic = mem_rdata.italic;
                    prod_word.word_index = word_counter_reg;
                    prod_word.row = emit_row_reg;
                    prod_word.rows_total = row_tally_reg;
                    prod_word.word_overflow = word_drop_reg;
                    emit_i_next = emit_i_reg + 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_END:
            begin
                if (!halted_reg && tag_fill_reg != '0)
                begin
                    rp_n_next = tag_fill_reg;
                    rp_k_next = '0;
                    tag_fill_next = '0;
                    rp_end_next = 1'b1;
                    state_next = S_RP;
                end
                else if (!halted_reg && word_fill_reg != '0)
                begin
                    close_end_next = 1'b1;
                    rp_mode_next = 1'b0;
                    state_next = S_CLOSE;
                end
                else
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                if (can_prod)
                begin
                    prod_fire = 1'b1;
                    prod_word.word_index = word_counter_reg;
                    prod_word.row = row_now_reg;
                    prod_word.rows_total = row_tally_reg;
                    prod_word.word_overflow = text_drop_reg;
                    prod_word.is_summary = 1'b1;
                    pen_x_next = '0;
                    pen_y_next = '0;
                    row_now_next = '0;
                    row_tally_next = 11'd1;
                    acc_next = '0;
                    word_fill_next = '0;
                    word_counter_next = '0;
                    color_now_next = '1;
                    italic_next = 1'b0;
                    tags_en_next = 1'b1;
                    tag_fill_next = '0;
                    halted_next = 1'b0;
                    word_drop_next = 1'b0;
                    text_drop_next = 1'b0;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!pend_v_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    push_last = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Output side: the newest word is held back until it is known whether it closes the item.
    always_comb
    begin
        pend_v_next = pend_v_reg;
        pend_next = pend_reg;
        out_v_next = out_v_reg && glyph_stall;
        out_next = out_reg;
        if (prod_fire)
        begin
            if (pend_v_reg)
            begin
                out_v_next = 1'b1;
                out_next = pend_reg;
            end
            pend_v_next = 1'b1;
            pend_next = prod_word;
        end
        else if (push_last)
        begin
            out_v_next = 1'b1;
            out_next = pend_reg;
            out_next.last = 1'b1;
            pend_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            font_size_reg <= 16'd4096;
            space_gap_reg <= 24'd4096;
            box_width_reg <= 24'd65535;
            box_height_reg <= 24'd65535;
            fb_en_reg <= 1'b1;
            fb_adv_reg <= 16'd8192;
            state_reg <= S_IDLE;
            rp_mode_reg <= 1'b0;
            rp_end_reg <= 1'b0;
            emit_ret_reg <= ER_CLOSE;
            close_end_reg <= 1'b0;
            close_nl_reg <= 1'b0;
            too_reg <= 1'b0;
            pen_x_reg <= '0;
            pen_y_reg <= '0;
            row_now_reg <= '0;
            row_tally_reg <= 11'd1;
            acc_reg <= '0;
            word_fill_reg <= '0;
            word_counter_reg <= '0;
            color_now_reg <= '1;
            italic_reg <= 1'b0;
            tags_en_reg <= 1'b1;
            tag_fill_reg <= '0;
            halted_reg <= 1'b0;
            word_drop_reg <= 1'b0;
            text_drop_reg <= 1'b0;
            rp_k_reg <= '0;
            rp_n_reg <= '0;
            emit_i_reg <= '0;
            pend_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            font_size_reg <= font_size_next;
            space_gap_reg <= space_gap_next;
            box_width_reg <= box_width_next;
            box_height_reg <= box_height_next;
            fb_en_reg <= fb_en_next;
            fb_adv_reg <= fb_adv_next;
            state_reg <= state_next;
            rp_mode_reg <= rp_mode_next;
            rp_end_reg <= rp_end_next;
            emit_ret_reg <= emit_ret_next;
            close_end_reg <= close_end_next;
            close_nl_reg <= close_nl_next;
            too_reg <= too_next;
            pen_x_reg <= pen_x_next;
            pen_y_reg <= pen_y_next;
            row_now_reg <= row_now_next;
            row_tally_reg <= row_tally_next;
            acc_reg <= acc_next;
            word_fill_reg <= word_fill_next;
            word_counter_reg <= word_counter_next;
            color_now_reg <= color_now_next;
            italic_reg <= italic_next;
            tags_en_reg <= tags_en_next;
            tag_fill_reg <= tag_fill_next;
            halted_reg <= halted_next;
            word_drop_reg <= word_drop_next;
            text_drop_reg <= text_drop_next;
            rp_k_reg <= rp_k_next;
            rp_n_reg <= rp_n_next;
            emit_i_reg <= emit_i_next;
            pend_v_reg <= pend_v_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_code_reg <= cur_code_next;
        cur_adv_reg <= cur_adv_next;
        cur_pr_reg <= cur_pr_next;
        glyph_w_reg <= glyph_w_next;
        ww_reg <= ww_next;
        emit_row_reg <= emit_row_next;
        pend_reg <= pend_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_code_reg[tag_waddr] <= tag_wcode;
            tag_adv_reg[tag_waddr] <= tag_wadv;
            tag_pr_reg[tag_waddr] <= tag_wpr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            word_mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
            mem_rdata <= word_mem[mem_raddr];
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        word_fill_reg <= rtwwm_pkg::FILL_W'(rtwwm_pkg::WORD_GLYPHS))
        else $error("word buffer fill beyond its depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        tag_fill_reg <= 4'(rtwwm_pkg::TAG_LEN))
        else $error("tag buffer fill beyond its depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        row_tally_reg == {1'b0, row_now_reg} + 11'd1)
        else $error("row count and current row out of step");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !pend_v_reg)
        else $error("held word left behind after an item finished");

endmodule
